// ----- design/emd_pkg.sv -----
// ----------------------------------------------------------------------------
// emd_pkg
// Shared types, constants and the transform function of the ECG
// morphological extremum detector.
// ----------------------------------------------------------------------------
package emd_pkg;

	// default configuration of the block
	localparam int RING_DEPTH_DEF  = 64;
	localparam int HALF_WINDOW_DEF = 4;
	localparam int LAG_MARGIN_DEF  = 8;
	localparam int TABLE_DEPTH_DEF = 32;
	localparam int WRAP_LIMIT_DEF  = 8;

	// field widths
	localparam int SAMPLE_W    = 12;
	localparam int VALUE_W     = 13;
	localparam int THRESH_W    = 12;
	localparam int POS_W       = 10;
	localparam int SLOT_W      = 5;
	localparam int CFG_INDEX_W = 2;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_HIGH_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LOW_THRESHOLD  = 2'd1;

	localparam logic [THRESH_W-1:0] HIGH_THRESHOLD_RST = 12'd180;
	localparam logic [THRESH_W-1:0] LOW_THRESHOLD_RST  = 12'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CALC,
		ST_DECIDE
	} emd_state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic calc;
		logic decide;
	} emd_cmd_t;

	typedef struct packed {
		logic scan_done;
	} emd_status_t;

	// floor(((mx + mn - 2x) * 10) / 16); gain of 10 as 8 + 2
	function automatic logic signed [VALUE_W-1:0] morph_value(
		input logic signed [SAMPLE_W-1:0] mx,
		input logic signed [SAMPLE_W-1:0] mn,
		input logic signed [SAMPLE_W-1:0] x
	);
		logic signed [SAMPLE_W+1:0] sum;
		logic signed [SAMPLE_W+5:0] prod;
		sum  = {{2{mx[SAMPLE_W-1]}}, mx} + {{2{mn[SAMPLE_W-1]}}, mn}
			- {x[SAMPLE_W-1], x, 1'b0};
		prod = ({{4{sum[SAMPLE_W+1]}}, sum} <<< 3) + ({{4{sum[SAMPLE_W+1]}}, sum} <<< 1);
		return prod[VALUE_W+3:4];
	endfunction

endpackage

// ----- design/emd_ring.sv -----
// ----------------------------------------------------------------------------
// emd_ring
// Sample ring: one write port, one registered read port, per-entry valid
// bits so that never-written entries read as zero.
// ----------------------------------------------------------------------------
module emd_ring #(
	parameter int RING_DEPTH = emd_pkg::RING_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [$clog2(RING_DEPTH)-1:0]       wr_addr,
	input  logic signed [emd_pkg::SAMPLE_W-1:0] wr_data,
	input  logic                                rd_en,
	input  logic [$clog2(RING_DEPTH)-1:0]       rd_addr,
	output logic signed [emd_pkg::SAMPLE_W-1:0] rd_data
);

	logic signed [emd_pkg::SAMPLE_W-1:0] mem_q [RING_DEPTH];
	logic [RING_DEPTH-1:0]               valid_q;
	logic signed [emd_pkg::SAMPLE_W-1:0] rd_data_s1;
	logic                                rd_valid_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_s1 <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_s1 ? rd_data_s1 : '0;

endmodule

// ----- design/emd_datapath.sv -----
// ----------------------------------------------------------------------------
// emd_datapath
// Ring addressing, three-lane window scan, transform, extremum decision and
// result register.
// ----------------------------------------------------------------------------
module emd_datapath #(
	parameter int RING_DEPTH  = emd_pkg::RING_DEPTH_DEF,
	parameter int HALF_WINDOW = emd_pkg::HALF_WINDOW_DEF,
	parameter int LAG_MARGIN  = emd_pkg::LAG_MARGIN_DEF,
	parameter int TABLE_DEPTH = emd_pkg::TABLE_DEPTH_DEF,
	parameter int WRAP_LIMIT  = emd_pkg::WRAP_LIMIT_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  emd_pkg::emd_cmd_t                      cmd,
	output emd_pkg::emd_status_t                   status,
	input  logic signed [emd_pkg::SAMPLE_W-1:0]    sample,
	input  logic                                   cfg_we,
	input  logic [emd_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  logic [emd_pkg::THRESH_W-1:0]           cfg_data,
	output logic                                   stored,
	output logic                                   reported,
	output logic                                   is_maximum,
	output logic [emd_pkg::POS_W-1:0]              position,
	output logic signed [emd_pkg::VALUE_W-1:0]     transform_value,
	output logic [emd_pkg::SLOT_W-1:0]             table_slot
);

	localparam int AW       = $clog2(RING_DEPTH);
	localparam int TW       = $clog2(TABLE_DEPTH);
	localparam int WW       = $clog2(WRAP_LIMIT + 1);
	localparam int SCAN_LEN = 2 * HALF_WINDOW + 3;
	localparam int CW       = $clog2(SCAN_LEN + 1);
	localparam int PW       = AW + WW + emd_pkg::POS_W;
	localparam int SW       = TW + emd_pkg::SLOT_W;

	localparam logic [AW-1:0] RING_LAST  = AW'(RING_DEPTH - 1);
	localparam logic [AW:0]   RING_SIZE  = (AW+1)'(RING_DEPTH);
	localparam logic [AW:0]   LAG_STEP   = (AW+1)'((1 + LAG_MARGIN) % RING_DEPTH);
	localparam logic [AW:0]   BACK_STEP  = (AW+1)'(RING_DEPTH - HALF_WINDOW);
	localparam logic [TW-1:0] TABLE_LAST = TW'(TABLE_DEPTH - 1);
	localparam logic [WW-1:0] WRAP_LAST  = WW'(WRAP_LIMIT - 1);
	localparam logic [CW-1:0] SCAN_END   = CW'(SCAN_LEN);

	localparam int SW_S = emd_pkg::SAMPLE_W;
	localparam int VW   = emd_pkg::VALUE_W;

	// configuration
	logic [emd_pkg::THRESH_W-1:0] high_thr_q, low_thr_q;

	// ring bookkeeping
	logic [AW-1:0] wi_q, wi_next, anchor, mid, start;
	logic [AW:0]   anchor_sum, start_sum;
	logic [WW-1:0] wc_q, wc_next, wraps;
	logic [AW-1:0] mid_q;
	logic [WW-1:0] wraps_q;

	// scan
	logic [AW-1:0] rd_addr_q;
	logic [CW-1:0] rd_cnt_q, acc_idx_q;
	logic          rd_pend_s1;
	logic          rd_issue;
	logic signed [SW_S-1:0] rd_data;
	logic signed [SW_S-1:0] mx_q [3];
	logic signed [SW_S-1:0] mn_q [3];
	logic signed [SW_S-1:0] x_q  [3];

	// transforms at anchor, anchor+1, anchor+2
	logic signed [VW-1:0] d_q, v1_q, v2_q;

	// decision
	logic signed [VW-1:0] plateau_q;
	logic [TW-1:0]        tp_q, tp_next;
	logic                 learning_q;
	logic [VW-1:0]        mag;
	logic                 qualifies, strict, plateau_end, store_c, is_max_c, plateau_start;
	logic [PW-1:0]        pos_full;
	logic [SW-1:0]        slot_wide;

	emd_ring #(
		.RING_DEPTH(RING_DEPTH)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd.load),
		.wr_addr(wi_q),
		.wr_data(sample),
		.rd_en  (rd_issue),
		.rd_addr(rd_addr_q),
		.rd_data(rd_data)
	);

	// analysis point and window start for the item being loaded
	always_comb begin
		wi_next    = (wi_q == RING_LAST) ? '0 : wi_q + 1'b1;
		anchor_sum = {1'b0, wi_next} + LAG_STEP;
		anchor     = (anchor_sum >= RING_SIZE) ? AW'(anchor_sum - RING_SIZE) : anchor_sum[AW-1:0];
		mid        = (anchor == RING_LAST) ? '0 : anchor + 1'b1;
		start_sum  = {1'b0, anchor} + BACK_STEP;
		start      = (start_sum >= RING_SIZE) ? AW'(start_sum - RING_SIZE) : start_sum[AW-1:0];
		if (anchor == '0) begin
			wc_next = (wc_q == WRAP_LAST) ? '0 : wc_q + 1'b1;
		end else begin
			wc_next = wc_q;
		end
		wraps = (mid != '0) ? wc_next : wc_next + 1'b1;
	end

	assign rd_issue         = cmd.scan && (rd_cnt_q != SCAN_END);
	assign status.scan_done = (rd_cnt_q == SCAN_END) && !rd_pend_s1;

	// extremum decision on the three transforms
	always_comb begin
		mag           = v1_q[VW-1] ? VW'(-v1_q) : v1_q;
		qualifies     = (mag > {1'b0, high_thr_q}) || (mag > {1'b0, low_thr_q});
		strict        = ((v1_q > v2_q) && (v1_q > d_q)) || ((v1_q < v2_q) && (v1_q < d_q));
		plateau_end   = (v1_q == d_q) &&
			(((plateau_q < v1_q) && (v1_q > v2_q)) || ((plateau_q > v1_q) && (v1_q < v2_q)));
		store_c       = qualifies && (strict || plateau_end);
		is_max_c      = strict ? ((v1_q > v2_q) && (v1_q > d_q))
			: ((plateau_q < v1_q) && (v1_q > v2_q));
		plateau_start = (v1_q == v2_q) && (v1_q != d_q) && qualifies;
		tp_next       = (tp_q == TABLE_LAST) ? '0 : tp_q + 1'b1;
		pos_full      = PW'(mid_q) + PW'(wraps_q) * PW'(RING_DEPTH);
		slot_wide     = SW'(tp_q);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_thr_q      <= emd_pkg::HIGH_THRESHOLD_RST;
			low_thr_q       <= emd_pkg::LOW_THRESHOLD_RST;
			wi_q            <= '0;
			wc_q            <= '0;
			rd_cnt_q        <= '0;
			acc_idx_q       <= '0;
			rd_pend_s1      <= 1'b0;
			plateau_q       <= '0;
			tp_q            <= '0;
			learning_q      <= 1'b1;
			stored          <= 1'b0;
			reported        <= 1'b0;
			is_maximum      <= 1'b0;
			position        <= '0;
			transform_value <= '0;
			table_slot      <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					emd_pkg::REG_HIGH_THRESHOLD: high_thr_q <= cfg_data;
					emd_pkg::REG_LOW_THRESHOLD:  low_thr_q  <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				wi_q       <= wi_next;
				wc_q       <= wc_next;
				rd_cnt_q   <= '0;
				acc_idx_q  <= '0;
				rd_pend_s1 <= 1'b0;
			end else if (cmd.scan) begin
				rd_pend_s1 <= rd_issue;
				if (rd_issue) begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
				end
				if (rd_pend_s1) begin
					acc_idx_q <= acc_idx_q + 1'b1;
				end
			end
			if (cmd.decide) begin
				if (plateau_start) begin
					plateau_q <= d_q;
				end
				if (store_c) begin
					tp_q <= tp_next;
					if (tp_next == '0) begin
						learning_q <= 1'b0;
					end
				end
				stored          <= store_c;
				reported        <= store_c && (!learning_q || (tp_next == '0));
				is_maximum      <= store_c && is_max_c;
				position        <= store_c ? pos_full[emd_pkg::POS_W-1:0] : '0;
				transform_value <= store_c ? v1_q : '0;
				table_slot      <= store_c ? slot_wide[emd_pkg::SLOT_W-1:0] : '0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mid_q     <= mid;
			wraps_q   <= wraps;
			rd_addr_q <= start;
			for (int c = 0; c < 3; c++) begin
				mx_q[c] <= '0;
				mn_q[c] <= '0;
			end
		end else if (cmd.scan) begin
			if (rd_issue) begin
				rd_addr_q <= (rd_addr_q == RING_LAST) ? '0 : rd_addr_q + 1'b1;
			end
			// lane c covers scan offsets c .. c + 2*HALF_WINDOW
			if (rd_pend_s1) begin
				for (int c = 0; c < 3; c++) begin
					if ((acc_idx_q >= CW'(c)) && (acc_idx_q <= CW'(c + 2 * HALF_WINDOW))) begin
						if (rd_data > mx_q[c]) begin
							mx_q[c] <= rd_data;
						end
						if (rd_data < mn_q[c]) begin
							mn_q[c] <= rd_data;
						end
					end
					if (acc_idx_q == CW'(c + HALF_WINDOW)) begin
						x_q[c] <= rd_data;
					end
				end
			end
		end
		if (cmd.calc) begin
			d_q  <= emd_pkg::morph_value(mx_q[0], mn_q[0], x_q[0]);
			v1_q <= emd_pkg::morph_value(mx_q[1], mn_q[1], x_q[1]);
			v2_q <= emd_pkg::morph_value(mx_q[2], mn_q[2], x_q[2]);
		end
	end

`ifndef SYNTHESIS
	a_report_needs_store: assert property (@(posedge clk) disable iff (!arst_n)
		reported |-> stored)
		else $error("reported result without a stored extremum");

	a_pointer_moves_on_store: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(tp_q) |-> $past(cmd.decide && store_c))
		else $error("table pointer advanced without a store");

	a_learning_stays_off: assert property (@(posedge clk) disable iff (!arst_n)
		!learning_q |=> !learning_q)
		else $error("learning pass restarted");
`endif

endmodule

// ----- design/emd_ctrl.sv -----
// ----------------------------------------------------------------------------
// emd_ctrl
// Sequencer: accept a sample, run the ring scan, compute transforms, then
// decide and hand the result to the output register.
// ----------------------------------------------------------------------------
module emd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  emd_pkg::emd_status_t status,
	output emd_pkg::emd_cmd_t    cmd
);

	emd_pkg::emd_state_t state_q, state_next;
	logic                out_valid_q;
	logic                out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			emd_pkg::ST_IDLE:   if (in_valid) state_next = emd_pkg::ST_SCAN;
			emd_pkg::ST_SCAN:   if (status.scan_done) state_next = emd_pkg::ST_CALC;
			emd_pkg::ST_CALC:   state_next = emd_pkg::ST_DECIDE;
			emd_pkg::ST_DECIDE: if (out_free) state_next = emd_pkg::ST_IDLE;
			default:            state_next = emd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = (state_q == emd_pkg::ST_IDLE);
		cmd.load   = (state_q == emd_pkg::ST_IDLE) && in_valid;
		cmd.scan   = (state_q == emd_pkg::ST_SCAN);
		cmd.calc   = (state_q == emd_pkg::ST_CALC);
		// hold the decision until the result register is free
		cmd.decide = (state_q == emd_pkg::ST_DECIDE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= emd_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.decide) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_decide_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == emd_pkg::ST_DECIDE && out_valid_q && !out_ready)
		|=> (state_q == emd_pkg::ST_DECIDE))
		else $error("decision overran a pending result");

	a_result_from_decide: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == emd_pkg::ST_DECIDE))
		else $error("result raised outside the decide step");
`endif

endmodule

// ----- design/ecg_morph_extremum_detector_core.sv -----
// ----------------------------------------------------------------------------
// ecg_morph_extremum_detector_core
// Morphological-transform extremum detector for filtered ECG samples.
// ----------------------------------------------------------------------------
// Each sample is written into the ring, then the ring is read once per cycle
// over the 2*HALF_WINDOW+3 positions that cover the windows of the analysis
// point and its two neighbors; three min/max lanes fill in parallel from the
// single read port of the sample ring. Scan, transform and decision run in
// order, and a new sample is taken only once the sequencer is back in idle
// after the decision on the last one; a result still waiting for transfer
// stalls the decision step, and no sample is taken meanwhile. Ring entries
// read as zero until written (valid bits clear at reset, no clearing pass).
// Thresholds are to be written by the user while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module ecg_morph_extremum_detector_core #(
	parameter int RING_DEPTH  = emd_pkg::RING_DEPTH_DEF,
	parameter int HALF_WINDOW = emd_pkg::HALF_WINDOW_DEF,
	parameter int LAG_MARGIN  = emd_pkg::LAG_MARGIN_DEF,
	parameter int TABLE_DEPTH = emd_pkg::TABLE_DEPTH_DEF,
	parameter int WRAP_LIMIT  = emd_pkg::WRAP_LIMIT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [emd_pkg::SAMPLE_W-1:0] sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                stored,
	output logic                                reported,
	output logic                                is_maximum,
	output logic [emd_pkg::POS_W-1:0]           position,
	output logic signed [emd_pkg::VALUE_W-1:0]  transform_value,
	output logic [emd_pkg::SLOT_W-1:0]          table_slot,
	input  logic                                cfg_we,
	input  logic [emd_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [emd_pkg::THRESH_W-1:0]        cfg_data
);

	emd_pkg::emd_cmd_t    cmd;
	emd_pkg::emd_status_t status;

	emd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd)
	);

	emd_datapath #(
		.RING_DEPTH (RING_DEPTH),
		.HALF_WINDOW(HALF_WINDOW),
		.LAG_MARGIN (LAG_MARGIN),
		.TABLE_DEPTH(TABLE_DEPTH),
		.WRAP_LIMIT (WRAP_LIMIT)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.sample         (sample),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.stored         (stored),
		.reported       (reported),
		.is_maximum     (is_maximum),
		.position       (position),
		.transform_value(transform_value),
		.table_slot     (table_slot)
	);

endmodule
